/* rtl/arpr_pkg.sv */
// Shared types and constants for the ARP responder with IPv4-to-MAC cache.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package arpr_pkg;

   localparam int CACHE_ENTRIES = 16;
   localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

   localparam logic [15:0] PTYPE_IPV4    = 16'h0800;
   localparam logic [15:0] OPC_REQUEST   = 16'd1;
   localparam logic [15:0] OPC_REPLY     = 16'd2;
   localparam logic [7:0]  ARP_HW_LEN    = 8'd6;
   localparam logic [7:0]  ARP_PROTO_LEN = 8'd4;

   localparam logic ACT_PACKET = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   // register map, 64-bit data, registers on 8-byte strides
   localparam int          CSR_ADDR_W          = 4;
   localparam logic [3:0]  CSR_ADDR_LOCAL_IP   = 4'h0;
   localparam logic [3:0]  CSR_ADDR_LOCAL_MAC  = 4'h8;

   localparam int REQ_TDATA_W = 160;
   localparam int RSP_TDATA_W = 136;

   typedef enum logic [2:0] {
      ST_LEARNED    = 3'd0,
      ST_REPLIED    = 3'd1,
      ST_BAD_HEADER = 3'd2,
      ST_BAD_OPCODE = 3'd3,
      ST_HIT        = 3'd4,
      ST_MISS       = 3'd5
   } arpr_status_type;

   typedef struct packed {
      logic        action;
      logic [15:0] ptype;
      logic [7:0]  hw_len;
      logic [7:0]  proto_len;
      logic [15:0] opcode;
      logic [47:0] src_mac;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
   } arpr_item_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture the accepted item
      logic match;   // register the cache compare
      logic commit;  // update cache and load the result register
   } arpr_cmd_type;

endpackage

/* rtl/arpr_csr.sv */
// Configuration registers local_ip and local_mac behind an APB-style port.
// Depends on arpr_pkg.
`timescale 1ns / 1ps

module arpr_csr
   import arpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [63:0]           csr_pwdata,
   output logic [63:0]           csr_prdata,
   output logic                  csr_pready,
   output logic [31:0]           local_ip
);

   logic [31:0] local_ip_ff;
   logic [47:0] local_mac_ff;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff  <= '0;
         local_mac_ff <= '0;
      end else if (wr_en) begin
         if (csr_paddr == CSR_ADDR_LOCAL_IP) begin
            local_ip_ff <= csr_pwdata[31:0];
         end
         if (csr_paddr == CSR_ADDR_LOCAL_MAC) begin
            local_mac_ff <= csr_pwdata[47:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == CSR_ADDR_LOCAL_IP) begin
         csr_prdata = {32'd0, local_ip_ff};
      end else if (csr_paddr == CSR_ADDR_LOCAL_MAC) begin
         csr_prdata = {16'd0, local_mac_ff};
      end
   end

   assign local_ip = local_ip_ff;

endmodule

/* rtl/arpr_ctrl.sv */
// Sequencing FSM: accept, match, commit; owns the input ready and result valid.
// Depends on arpr_pkg (command struct).
`timescale 1ns / 1ps

module arpr_ctrl
   import arpr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output arpr_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_COMMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   // result slot is free if empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.load   = req_tvalid && req_tready;
   assign cmd.match  = (state_ff == S_MATCH);
   assign cmd.commit = (state_ff == S_COMMIT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_MATCH;
               end
            end
            S_MATCH: begin
               state_ff <= S_COMMIT;
            end
            S_COMMIT: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_match_after_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.match)
      else $error("match step did not follow an accepted item");

   a_commit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_tvalid || rsp_tready))
      else $error("result committed over an untaken result");

   a_no_accept_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.match |-> !req_tready)
      else $error("input accepted while an item is in flight");

endmodule

/* rtl/arpr_dp.sv */
// Datapath: item register, 16-lane associative cache, round-robin replacement,
// result computation and output register. Depends on arpr_pkg.
`timescale 1ns / 1ps

module arpr_dp
   import arpr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  arpr_cmd_type    cmd,
   input  arpr_item_type   item,
   input  logic [31:0]     local_ip,
   output arpr_status_type rsp_status,
   output logic            rsp_send_reply,
   output logic [47:0]     rsp_reply_dst_mac,
   output logic [31:0]     rsp_reply_dst_ip,
   output logic            rsp_mac_changed,
   output logic [47:0]     rsp_lookup_mac
);

   // lowest set bit wins
   function automatic logic [IDX_W-1:0] first_set(input logic [CACHE_ENTRIES-1:0] vec);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

   arpr_item_type item_ff;

   logic [CACHE_ENTRIES-1:0] entry_valid_ff;
   logic [31:0]              entry_ip_ff  [CACHE_ENTRIES];
   logic [47:0]              entry_mac_ff [CACHE_ENTRIES];
   logic [IDX_W-1:0]         rptr_ff;
   logic [IDX_W-1:0]         rptr_in;

   logic [CACHE_ENTRIES-1:0] hit_vec;
   logic                     hit_ff;
   logic [IDX_W-1:0]         hit_idx_ff;
   logic                     free_ff;
   logic [IDX_W-1:0]         free_idx_ff;

   logic [47:0]     hit_mac;
   logic            hdr_ok;
   logic            learn_en;
   logic            changed;
   arpr_status_type status_in;
   logic            send_in;

   arpr_status_type status_ff;
   logic            send_ff;
   logic [47:0]     rmac_ff;
   logic [31:0]     rip_ff;
   logic            changed_ff;
   logic [47:0]     lmac_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= item;
      end
   end

   // one comparator lane per entry
   always_comb begin
      for (int i = 0; i < CACHE_ENTRIES; i++) begin
         hit_vec[i] = entry_valid_ff[i] && (entry_ip_ff[i] == item_ff.src_ip);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         hit_ff      <= |hit_vec;
         hit_idx_ff  <= first_set(hit_vec);
         free_ff     <= ~&entry_valid_ff;
         free_idx_ff <= first_set(~entry_valid_ff);
      end
   end

   assign hit_mac  = entry_mac_ff[hit_idx_ff];
   assign hdr_ok   = (item_ff.ptype == PTYPE_IPV4) &&
                     (item_ff.hw_len == ARP_HW_LEN) &&
                     (item_ff.proto_len == ARP_PROTO_LEN);
   assign learn_en = (item_ff.action == ACT_PACKET) && hdr_ok;
   assign changed  = learn_en && hit_ff && (hit_mac != item_ff.src_mac);
   assign rptr_in  = (rptr_ff == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : rptr_ff + 1'b1;

   always_comb begin
      send_in = 1'b0;
      priority if (item_ff.action == ACT_LOOKUP) begin
         status_in = hit_ff ? ST_HIT : ST_MISS;
      end else if (!hdr_ok) begin
         status_in = ST_BAD_HEADER;
      end else if (item_ff.opcode == OPC_REQUEST) begin
         send_in   = (item_ff.dst_ip == local_ip);
         status_in = send_in ? ST_REPLIED : ST_LEARNED;
      end else if (item_ff.opcode == OPC_REPLY) begin
         status_in = ST_LEARNED;
      end else begin
         status_in = ST_BAD_OPCODE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rptr_ff        <= '0;
      end else if (cmd.commit && learn_en && !hit_ff) begin
         if (free_ff) begin
            entry_valid_ff[free_idx_ff] <= 1'b1;
         end else begin
            rptr_ff <= rptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && learn_en) begin
         if (hit_ff) begin
            entry_mac_ff[hit_idx_ff] <= item_ff.src_mac;
         end else if (free_ff) begin
            entry_ip_ff[free_idx_ff]  <= item_ff.src_ip;
            entry_mac_ff[free_idx_ff] <= item_ff.src_mac;
         end else begin
            entry_ip_ff[rptr_ff]  <= item_ff.src_ip;
            entry_mac_ff[rptr_ff] <= item_ff.src_mac;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff  <= status_in;
         send_ff    <= send_in;
         rmac_ff    <= send_in ? item_ff.src_mac : 48'd0;
         rip_ff     <= send_in ? item_ff.src_ip : 32'd0;
         changed_ff <= changed;
         lmac_ff    <= (item_ff.action == ACT_LOOKUP && hit_ff) ? hit_mac : 48'd0;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_send_reply    = send_ff;
   assign rsp_reply_dst_mac = rmac_ff;
   assign rsp_reply_dst_ip  = rip_ff;
   assign rsp_mac_changed   = changed_ff;
   assign rsp_lookup_mac    = lmac_ff;

   // an IP is never cached twice
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      cmd.match |-> $onehot0(hit_vec))
      else $error("IP present in more than one cache entry");

   a_valid_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> ($countones(entry_valid_ff) >= $past($countones(entry_valid_ff))))
      else $error("cache entry lost its valid bit");

   a_rptr_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (rptr_ff != $past(rptr_ff))) |-> $past(&entry_valid_ff))
      else $error("replacement pointer moved with free entries left");

endmodule

/* rtl/arp_responder_with_cache.sv */
// Top level of the ARP responder with IPv4-to-MAC cache.
// Depends on arpr_pkg, arpr_csr, arpr_ctrl and arpr_dp.
//
// Usage:
//  - req channel: one parsed ARP packet (tuser = 0) or one cache lookup
//    (tuser = 1, only the source IP is used) per item.
//  - rsp channel: exactly one result item per request item, in order.
//  - csr port: local_ip at 0x0, local_mac at 0x8; write only while idle.
// Sequence: for each accepted item the match state registers the cache
//  compare, then the commit state loads the result register and raises
//  rsp_tvalid. The next item is accepted only after the commit, since the
//  compare/commit sequence shares the cache between consecutive items.
// Reset: the cache is emptied, the replacement pointer and both registers
//  go to zero; no clearing pass is needed.
// Stall: a finished result waits in the output register; the next item is
//  accepted and compared, and is committed once the result is taken.
`timescale 1ns / 1ps

module arp_responder_with_cache
   import arpr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [15:0] ptype, [23:16] hw_len, [31:24] proto_len, [47:32] opcode,
   // [95:48] src_mac, [127:96] src_ip, [159:128] dst_ip
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [0] action
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] send_reply, [48:1] reply_dst_mac, [80:49] reply_dst_ip,
   // [81] mac_changed, [129:82] lookup_mac, [135:130] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [2:0] status
   output logic [2:0]             rsp_tuser,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [63:0]            csr_pwdata,
   output logic [63:0]            csr_prdata,
   output logic                   csr_pready
);

   arpr_cmd_type    cmd;
   arpr_item_type   item;
   logic [31:0]     local_ip;
   arpr_status_type status;
   logic            send_reply;
   logic [47:0]     reply_dst_mac;
   logic [31:0]     reply_dst_ip;
   logic            mac_changed;
   logic [47:0]     lookup_mac;

   assign item.action    = req_tuser;
   assign item.ptype     = req_tdata[15:0];
   assign item.hw_len    = req_tdata[23:16];
   assign item.proto_len = req_tdata[31:24];
   assign item.opcode    = req_tdata[47:32];
   assign item.src_mac   = req_tdata[95:48];
   assign item.src_ip    = req_tdata[127:96];
   assign item.dst_ip    = req_tdata[159:128];

   arpr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .local_ip    (local_ip)
   );

   arpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   arpr_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .item              (item),
      .local_ip          (local_ip),
      .rsp_status        (status),
      .rsp_send_reply    (send_reply),
      .rsp_reply_dst_mac (reply_dst_mac),
      .rsp_reply_dst_ip  (reply_dst_ip),
      .rsp_mac_changed   (mac_changed),
      .rsp_lookup_mac    (lookup_mac)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = {6'd0, lookup_mac, mac_changed, reply_dst_ip,
                       reply_dst_mac, send_reply};

endmodule

/* dv/arp_responder_with_cache_tb.sv */
// Self-checking testbench for arp_responder_with_cache: directed and random ARP items,
// register changes between phases, a scoreboard class that models the IPv4-to-MAC cache.
// Depends on arpr_pkg and the RTL of arp_responder_with_cache.
`timescale 1ns / 1ps

module arp_responder_with_cache_tb;
   import arpr_pkg::*;

   localparam int POOL_IPS    = 24;
   localparam int POOL_MACS   = 4;
   localparam int PHASE_ITEMS = 400;

   typedef struct {
      arpr_status_type status;
      logic            send;
      logic [47:0]     rmac;
      logic [31:0]     rip;
      logic            changed;
      logic [47:0]     lmac;
   } arp_result_type;

   class arp_scoreboard;
      logic [31:0] local_ip;
      logic [47:0] local_mac;
      bit          valid[CACHE_ENTRIES];
      logic [31:0] ip_tab[CACHE_ENTRIES];
      logic [47:0] mac_tab[CACHE_ENTRIES];
      int unsigned next_victim;
      arp_result_type expected_q[$];
      int          errors;

      function new();
         local_ip    = '0;
         local_mac   = '0;
         next_victim = 0;
         errors      = 0;
         foreach (valid[i]) valid[i] = 1'b0;
      endfunction

      function int find_slot(logic [31:0] ip);
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (valid[i] && ip_tab[i] == ip) return i;
         end
         return -1;
      endfunction

      // returns 1 when a cached IP got a different MAC
      function logic learn(logic [31:0] ip, logic [47:0] mac);
         int s;
         s = find_slot(ip);
         if (s >= 0) begin
            if (mac_tab[s] == mac) return 1'b0;
            mac_tab[s] = mac;
            return 1'b1;
         end
         for (int i = 0; i < CACHE_ENTRIES; i++) begin
            if (!valid[i]) begin
               valid[i]   = 1'b1;
               ip_tab[i]  = ip;
               mac_tab[i] = mac;
               return 1'b0;
            end
         end
         // cache full: round-robin victim
         ip_tab[next_victim]  = ip;
         mac_tab[next_victim] = mac;
         next_victim = (next_victim + 1) % CACHE_ENTRIES;
         return 1'b0;
      endfunction

      function void note_item(arpr_item_type it);
         arp_result_type r;
         int             s;
         r.status  = ST_LEARNED;
         r.send    = 1'b0;
         r.rmac    = '0;
         r.rip     = '0;
         r.changed = 1'b0;
         r.lmac    = '0;
         if (it.action == ACT_LOOKUP) begin
            s = find_slot(it.src_ip);
            if (s >= 0) begin
               r.status = ST_HIT;
               r.lmac   = mac_tab[s];
            end else begin
               r.status = ST_MISS;
            end
         end else if (it.ptype != PTYPE_IPV4 || it.hw_len != ARP_HW_LEN ||
                      it.proto_len != ARP_PROTO_LEN) begin
            r.status = ST_BAD_HEADER;
         end else begin
            r.changed = learn(it.src_ip, it.src_mac);
            if (it.opcode == OPC_REQUEST) begin
               if (it.dst_ip == local_ip) begin
                  r.status = ST_REPLIED;
                  r.send   = 1'b1;
                  r.rmac   = it.src_mac;
                  r.rip    = it.src_ip;
               end
            end else if (it.opcode != OPC_REPLY) begin
               r.status = ST_BAD_OPCODE;
            end
         end
         expected_q.push_back(r);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      function void check_result(logic [2:0] status, logic [RSP_TDATA_W-1:0] d);
         arp_result_type r;
         if (expected_q.size() == 0) begin
            flag($sformatf("%0t: result item with none expected, status %0d", $realtime,
                           status));
            return;
         end
         r = expected_q.pop_front();
         if (status !== r.status || d[0] !== r.send || d[48:1] !== r.rmac ||
             d[80:49] !== r.rip || d[81] !== r.changed || d[129:82] !== r.lmac ||
             d[135:130] !== '0)
            flag($sformatf({"%0t: mismatch exp status %0d send %0d rmac %h rip %h chg %0d ",
                            "lmac %h / got status %0d send %0d rmac %h rip %h chg %0d ",
                            "lmac %h pad %h"}, $realtime,
                           r.status, r.send, r.rmac, r.rip, r.changed, r.lmac,
                           status, d[0], d[48:1], d[80:49], d[81], d[129:82], d[135:130]));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [2:0]             rsp_tuser;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [63:0]            csr_pwdata = '0;
   logic [63:0]            csr_prdata;
   logic                   csr_pready;

   arp_scoreboard sb;
   int unsigned   tx_idle_pct = 0;
   int unsigned   rx_stall_pct = 0;
   logic [31:0]   ip_pool[POOL_IPS];
   logic [47:0]   mac_pool[POOL_MACS];

   arp_responder_with_cache dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
   end

   function automatic logic [47:0] rand48();
      return {16'($urandom()), 32'($urandom())};
   endfunction

   function automatic arpr_item_type arp_packet(logic [15:0] op, logic [47:0] smac,
                                                logic [31:0] sip, logic [31:0] tip);
      arpr_item_type it;
      it.action    = ACT_PACKET;
      it.ptype     = PTYPE_IPV4;
      it.hw_len    = ARP_HW_LEN;
      it.proto_len = ARP_PROTO_LEN;
      it.opcode    = op;
      it.src_mac   = smac;
      it.src_ip    = sip;
      it.dst_ip    = tip;
      return it;
   endfunction

   // mostly well-formed packets over a small IP pool so the cache fills and recycles
   function automatic arpr_item_type gen_item();
      arpr_item_type it;
      int unsigned   k;
      int unsigned   sel;
      it.action    = 1'($urandom());
      it.ptype     = 16'($urandom());
      it.hw_len    = 8'($urandom());
      it.proto_len = 8'($urandom());
      it.opcode    = 16'($urandom());
      it.src_mac   = rand48();
      it.src_ip    = $urandom();
      it.dst_ip    = $urandom();
      k = $urandom_range(0, 99);
      if (k < 55) begin
         it.action    = ACT_PACKET;
         it.ptype     = PTYPE_IPV4;
         it.hw_len    = ARP_HW_LEN;
         it.proto_len = ARP_PROTO_LEN;
         sel = $urandom_range(0, 99);
         if (sel < 45) it.opcode = OPC_REQUEST;
         else if (sel < 80) it.opcode = OPC_REPLY;
         else if (sel < 88) it.opcode = 16'($urandom_range(0, 3));
         if ($urandom_range(0, 99) < 85) it.src_ip = ip_pool[$urandom_range(0, POOL_IPS - 1)];
         if ($urandom_range(0, 1)) it.src_mac = mac_pool[$urandom_range(0, POOL_MACS - 1)];
         sel = $urandom_range(0, 99);
         if (sel < 45) it.dst_ip = sb.local_ip;
         else if (sel < 70) it.dst_ip = ip_pool[$urandom_range(0, POOL_IPS - 1)];
      end else if (k < 80) begin
         it.action = ACT_LOOKUP;
         if ($urandom_range(0, 99) < 80) it.src_ip = ip_pool[$urandom_range(0, POOL_IPS - 1)];
      end else begin
         // noise: fully random, or a good header with one field broken
         it.action = ACT_PACKET;
         sel = $urandom_range(0, 3);
         if (sel != 0) begin
            it.ptype     = PTYPE_IPV4;
            it.hw_len    = ARP_HW_LEN;
            it.proto_len = ARP_PROTO_LEN;
            unique case (sel)
               1: it.ptype  = 16'($urandom());
               2: it.hw_len = 8'($urandom());
               default: it.proto_len = 8'($urandom());
            endcase
         end
      end
      return it;
   endfunction

   task automatic send_item(input arpr_item_type it);
      @(negedge clock);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.action;
      req_tdata  <= {it.dst_ip, it.src_ip, it.src_mac, it.opcode,
                     it.proto_len, it.hw_len, it.ptype};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(it);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [63:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_regs(input logic [31:0] ip, input logic [47:0] mac);
      csr_write(CSR_ADDR_LOCAL_IP, {32'h0, ip});
      sb.local_ip = ip;
      csr_write(CSR_ADDR_LOCAL_MAC, {16'h0, mac});
      sb.local_mac = mac;
   endtask

   initial begin
      #1_000_000;
      $display("arp_responder_with_cache_tb failed");
      $finish;
   end

   initial begin
      arpr_item_type it;
      logic [31:0]   ip_a;
      logic [31:0]   ip_b;
      logic [31:0]   ip_c;
      logic [47:0]   mac_a;
      logic [47:0]   mac_b;
      sb = new();
      ip_pool[0] = 32'h0;
      ip_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_IPS; i++) ip_pool[i] = $urandom();
      mac_pool[0] = 48'h0;
      mac_pool[1] = 48'hFFFF_FFFF_FFFF;
      for (int i = 2; i < POOL_MACS; i++) mac_pool[i] = rand48();
      ip_a  = 32'hC0A8_0010;
      ip_b  = 32'hC0A8_0020;
      ip_c  = 32'h0A00_0003;
      mac_a = 48'h0011_2233_4455;
      mac_b = 48'h00AA_BBCC_DDEE;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      set_regs(32'hC0A8_0001, 48'h0200_5E00_0001);

      // directed part
      send_item('{ACT_LOOKUP, 16'h0, 8'h0, 8'h0, 16'h0, 48'h0, ip_a, 32'h0});  // empty cache
      it = arp_packet(OPC_REQUEST, mac_a, ip_a, sb.local_ip);
      it.ptype = 16'h0806;
      send_item(it);
      it = arp_packet(OPC_REQUEST, mac_a, ip_a, sb.local_ip);
      it.hw_len = 8'h0;
      send_item(it);
      it = arp_packet(OPC_REQUEST, mac_a, ip_a, sb.local_ip);
      it.proto_len = 8'hFF;
      send_item(it);
      send_item('{ACT_PACKET, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF});
      send_item('{ACT_PACKET, 16'h0, 8'h0, 8'h0, 16'h0, 48'h0, 32'h0, 32'h0});
      send_item(arp_packet(OPC_REQUEST, mac_a, ip_a, sb.local_ip));  // request for us
      send_item('{ACT_LOOKUP, 16'h0, 8'h0, 8'h0, 16'h0, 48'h0, ip_a, 32'h0});
      send_item(arp_packet(OPC_REQUEST, mac_b, ip_b, 32'hC0A8_0002));  // not for us
      send_item(arp_packet(OPC_REPLY, mac_a, ip_a, sb.local_ip));  // same MAC
      send_item(arp_packet(OPC_REPLY, mac_b, ip_a, 32'h0));  // MAC changes
      send_item(arp_packet(16'h0000, mac_a, ip_c, 32'h0));
      send_item(arp_packet(16'hFFFF, mac_b, ip_a, sb.local_ip));
      send_item(arp_packet(16'h0003, mac_a, ip_a, sb.local_ip));
      send_item('{ACT_LOOKUP, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF,
                  ip_c, 32'hFFFF_FFFF});
      send_item(arp_packet(OPC_REQUEST, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF));
      send_item(arp_packet(OPC_REPLY, 48'h0, 32'h0, 32'h0));
      send_item('{ACT_LOOKUP, 16'h0, 8'h0, 8'h0, 16'h0, 48'h0, 32'hFFFF_FFFF, 32'h0});
      send_item('{ACT_LOOKUP, 16'h0, 8'h0, 8'h0, 16'h0, 48'h0, 32'h0, 32'h0});
      send_item('{ACT_LOOKUP, 16'h0, 8'h0, 8'h0, 16'h0, 48'h0, ip_b, 32'h0});
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         unique case (ph)
            0: begin
               tx_idle_pct = 0;  rx_stall_pct = 0;
               set_regs(32'h0, 48'h0);
            end
            1: begin
               tx_idle_pct = 48; rx_stall_pct = 0;
               set_regs(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
            end
            2: begin
               tx_idle_pct = 0;  rx_stall_pct = 48;
               set_regs(ip_pool[5], rand48());
            end
            default: begin
               tx_idle_pct = 8;  rx_stall_pct = 8;
               set_regs($urandom(), rand48());
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) wait_drained();
            send_item(gen_item());
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("arp_responder_with_cache_tb passed");
      end else begin
         $display("arp_responder_with_cache_tb failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/arpr_pkg.sv
rtl/arpr_csr.sv
rtl/arpr_ctrl.sv
rtl/arpr_dp.sv
rtl/arp_responder_with_cache.sv
dv/arp_responder_with_cache_tb.sv
